// ----- src/mgbt_pkg.sv -----
// shared constants, types and saturation helpers of the min gap bias tracker
// no dependencies; used by the channel interfaces, the grid store and the core
package mgbt_pkg;

  // grid geometry and number format
  localparam int unsigned MAX_ROWS    = 64;
  localparam int unsigned MAX_COLS    = 64;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned ROW_W       = $clog2(MAX_ROWS);
  localparam int unsigned COL_W       = $clog2(MAX_COLS);
  localparam int unsigned SITE_W      = ROW_W + COL_W;
  localparam int unsigned GRID_DEPTH  = MAX_ROWS * MAX_COLS;

  // field widths
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned ROW_FIELD_W = 6;
  localparam int unsigned COL_FIELD_W = 6;
  localparam int unsigned HEIGHT_W    = 32;
  localparam int unsigned ENERGY_W    = 48;
  localparam int unsigned DIFF_W      = HEIGHT_W + 1;
  localparam int unsigned PROD_W      = HEIGHT_W + DIFF_W;
  localparam int unsigned DIM_CFG_W   = 7;

  // configuration port
  localparam int unsigned CFG_ADDR_W  = 4;
  localparam int unsigned APB_DATA_W  = 32;

  // reset values
  localparam logic signed [HEIGHT_W-1:0] GAP_MAX = {1'b0, {(HEIGHT_W-1){1'b1}}};
  localparam logic signed [HEIGHT_W-1:0] GAP_MIN = {1'b1, {(HEIGHT_W-1){1'b0}}};
  localparam logic signed [ENERGY_W-1:0] ENERGY_MAX = {1'b0, {(ENERGY_W-1){1'b1}}};
  localparam logic signed [ENERGY_W-1:0] ENERGY_MIN = {1'b1, {(ENERGY_W-1){1'b0}}};
  localparam logic signed [HEIGHT_W-1:0] STRENGTH_RST = HEIGHT_W'(1 << FRAC_BITS);
  localparam logic [DIM_CFG_W-1:0] ROWS_RST = DIM_CFG_W'(MAX_ROWS);
  localparam logic [DIM_CFG_W-1:0] COLS_RST = DIM_CFG_W'(MAX_COLS);

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD    = 2'd0,
    CMD_RESCAN  = 2'd1,
    CMD_PROPOSE = 2'd2,
    CMD_COMMIT  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_BIAS_STRENGTH = 2'd0,
    REG_TARGET_GAP    = 2'd1,
    REG_ROWS_USED     = 2'd2,
    REG_COLS_USED     = 2'd3
  } reg_e;

  // one write into the height grid
  typedef struct packed {
    logic                en;
    logic                surface;
    logic [SITE_W-1:0]   addr;
    logic [HEIGHT_W-1:0] data;
  } grid_wr_t;

  // clamp a widened difference back to a gap
  function automatic logic signed [HEIGHT_W-1:0] sat_gap(input logic signed [DIFF_W-1:0] x);
    logic signed [HEIGHT_W-1:0] r;
    if (x[DIFF_W-1] != x[DIFF_W-2]) begin
      r = x[DIFF_W-1] ? GAP_MIN : GAP_MAX;
    end else begin
      r = x[HEIGHT_W-1:0];
    end
    return r;
  endfunction

  // clamp a wide signed value to the energy range
  function automatic logic signed [ENERGY_W-1:0] sat_energy(input logic signed [PROD_W-1:0] x);
    logic [PROD_W-ENERGY_W:0]   upper;
    logic signed [ENERGY_W-1:0] r;
    upper = x[PROD_W-1:ENERGY_W-1];
    if ((&upper) || !(|upper)) begin
      r = x[ENERGY_W-1:0];
    end else begin
      r = x[PROD_W-1] ? ENERGY_MIN : ENERGY_MAX;
    end
    return r;
  endfunction

  // zero acts as one, anything above the store size acts as the store size
  function automatic logic [DIM_CFG_W-1:0] eff_dim(input logic [DIM_CFG_W-1:0] v,
                                                   input logic [DIM_CFG_W-1:0] lim);
    logic [DIM_CFG_W-1:0] r;
    if (v == '0) begin
      r = DIM_CFG_W'(1);
    end else if (v > lim) begin
      r = lim;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ----- src/mgbt_in_if.sv -----
// command channel of the min gap bias tracker: valid/ready plus one command item
// depends on mgbt_pkg for the field widths
interface mgbt_in_if import mgbt_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [CMD_W-1:0]           cmd;
  logic [ROW_FIELD_W-1:0]     row;
  logic [COL_FIELD_W-1:0]     col;
  logic                       surface;
  logic signed [HEIGHT_W-1:0] height;

  modport source (output valid, cmd, row, col, surface, height, input ready);
  modport sink   (input valid, cmd, row, col, surface, height, output ready);
endinterface

// ----- src/mgbt_out_if.sv -----
// result channel of the min gap bias tracker: valid/ready plus one result item
// depends on mgbt_pkg for the field widths
interface mgbt_out_if import mgbt_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [ENERGY_W-1:0] delta_energy;
  logic signed [ENERGY_W-1:0] bias_energy;
  logic signed [HEIGHT_W-1:0] min_gap;
  logic [ROW_FIELD_W-1:0]     min_row;
  logic [COL_FIELD_W-1:0]     min_col;

  modport source (output valid, delta_energy, bias_energy, min_gap, min_row, min_col,
                  input ready);
  modport sink   (input valid, delta_energy, bias_energy, min_gap, min_row, min_col,
                  output ready);
endinterface

// ----- src/min_gap_bias_tracker_core.sv -----
// min gap bias tracker core: command fsm, min gap scan, bias energy arithmetic
// depends on mgbt_pkg, mgbt_in_if, mgbt_out_if and mgbt_grid
//
// usage
//   in_i carries commands: load one height, rescan the grid, propose a move,
//   commit the pending proposal. every command gives exactly one transfer on
//   out_o with the proposal's energy change (zero for other commands), the
//   total bias energy, and the committed minimum gap and its site.
//   registers (bias strength, target gap, rows and columns used) sit at 4*index on
//   the apb port; the user must write them only while the block is idle, unchecked.
// sequence and throughput
//   one command at a time. load and commit go straight to the output register.
//   proposal away from the minimum site: grid read, gap compare, difference,
//   multiply, scale and saturate, output. rescan: a walk of rows_used*cols_used
//   sites, then difference onward; a proposal at the minimum site does the same
//   walk after the gap compare; one grid site read per cycle through the
//   single read port of the grid memories.
// reset
//   energy zero, minimum at its largest value at site (0,0), no pending
//   proposal; the grids are undefined until loaded and need no clearing pass.
// stalls
//   a finished result waits in the output register; the next command is
//   taken meanwhile and its result is held back until the output frees up.
module min_gap_bias_tracker_core import mgbt_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  mgbt_in_if.sink               in_i,
  mgbt_out_if.source            out_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_PGAP  = 8'b0000_0010,
    ST_SCAN  = 8'b0000_0100,
    ST_DRAIN = 8'b0000_1000,
    ST_DIFF  = 8'b0001_0000,
    ST_MUL   = 8'b0010_0000,
    ST_SAT   = 8'b0100_0000,
    ST_EMIT  = 8'b1000_0000
  } state_e;

  state_e state_q;

  // configuration registers
  logic signed [HEIGHT_W-1:0] strength_q;
  logic signed [HEIGHT_W-1:0] target_q;
  logic [DIM_CFG_W-1:0]       rows_q;
  logic [DIM_CFG_W-1:0]       cols_q;

  // accepted command
  cmd_e                       cmd_q;
  logic [ROW_W-1:0]           row_q;
  logic [COL_W-1:0]           col_q;
  logic                       surf_q;
  logic signed [HEIGHT_W-1:0] height_q;

  // committed and pending tracker state
  logic signed [ENERGY_W-1:0] energy_q;
  logic signed [HEIGHT_W-1:0] com_min_q;
  logic [ROW_W-1:0]           com_row_q;
  logic [COL_W-1:0]           com_col_q;
  logic signed [HEIGHT_W-1:0] pend_min_q;
  logic [ROW_W-1:0]           pend_row_q;
  logic [COL_W-1:0]           pend_col_q;
  logic signed [ENERGY_W-1:0] pend_delta_q;
  logic [SITE_W-1:0]          moved_site_q;
  logic signed [HEIGHT_W-1:0] moved_height_q;
  logic                       moved_surf_q;
  logic                       pend_valid_q;

  // scan datapath
  logic [ROW_W-1:0]           scan_row_q;
  logic [COL_W-1:0]           scan_col_q;
  logic                       rd_vld_q;
  logic [SITE_W-1:0]          rd_site_q;
  logic                       first_q;
  logic                       skip_q;
  logic signed [HEIGHT_W-1:0] best_q;
  logic [ROW_W-1:0]           best_row_q;
  logic [COL_W-1:0]           best_col_q;

  // energy datapath
  logic signed [DIFF_W-1:0]   diff_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [ENERGY_W-1:0] delta_q;

  // output register
  logic                       out_valid_q;
  logic signed [ENERGY_W-1:0] out_delta_q;
  logic signed [ENERGY_W-1:0] out_energy_q;
  logic signed [HEIGHT_W-1:0] out_min_q;
  logic [ROW_W-1:0]           out_row_q;
  logic [COL_W-1:0]           out_col_q;

  logic                       accept;
  cmd_e                       in_cmd;
  logic [SITE_W-1:0]          in_site;
  logic [SITE_W-1:0]          rd_addr;
  grid_wr_t                   grid_wr;
  logic signed [HEIGHT_W-1:0] rd_top;
  logic signed [HEIGHT_W-1:0] rd_bot;
  logic signed [HEIGHT_W-1:0] prop_gap;
  logic signed [HEIGHT_W-1:0] scan_gap;
  logic                       scan_take;
  logic [DIM_CFG_W-1:0]       eff_rows_m1;
  logic [DIM_CFG_W-1:0]       eff_cols_m1;
  logic                       last_col;
  logic                       last_site;
  logic signed [HEIGHT_W-1:0] ref_gap;
  logic signed [PROD_W-1:0]   scaled;
  logic signed [ENERGY_W-1:0] energy_new;
  logic signed [PROD_W-1:0]   energy_sum;
  logic                       cfg_wr;
  reg_e                       cfg_idx;
  logic                       out_free;

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strength_q <= STRENGTH_RST;
      target_q   <= '0;
      rows_q     <= ROWS_RST;
      cols_q     <= COLS_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_BIAS_STRENGTH: strength_q <= pwdata;
        REG_TARGET_GAP:    target_q   <= pwdata;
        REG_ROWS_USED:     rows_q     <= pwdata[DIM_CFG_W-1:0];
        REG_COLS_USED:     cols_q     <= pwdata[DIM_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_BIAS_STRENGTH: prdata = strength_q;
      REG_TARGET_GAP:    prdata = target_q;
      REG_ROWS_USED:     prdata = APB_DATA_W'(rows_q);
      REG_COLS_USED:     prdata = APB_DATA_W'(cols_q);
      default:           prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // grid store: loads and commits write at the transfer edge, reads are
  // either the proposed site or the scan walk
  // ---------------------------------------------------------------------------
  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign in_cmd     = cmd_e'(in_i.cmd);
  // sites beyond the store wrap on the low row and column bits
  assign in_site    = {in_i.row[ROW_W-1:0], in_i.col[COL_W-1:0]};
  assign rd_addr    = (state_q == ST_SCAN) ? {scan_row_q, scan_col_q} : in_site;

  always_comb begin
    grid_wr = '0;
    if (accept) begin
      if (in_cmd == CMD_LOAD) begin
        grid_wr.en      = 1'b1;
        grid_wr.surface = in_i.surface;
        grid_wr.addr    = in_site;
        grid_wr.data    = in_i.height;
      end else if (in_cmd == CMD_COMMIT && pend_valid_q) begin
        grid_wr.en      = 1'b1;
        grid_wr.surface = moved_surf_q;
        grid_wr.addr    = moved_site_q;
        grid_wr.data    = moved_height_q;
      end
    end
  end

  mgbt_grid u_grid (
    .clk_i     (clk_i),
    .wr_i      (grid_wr),
    .rd_addr_i (rd_addr),
    .rd_top_o  (rd_top),
    .rd_bot_o  (rd_bot)
  );

  // ---------------------------------------------------------------------------
  // gap logic
  // ---------------------------------------------------------------------------
  // proposed gap: the moved sheet takes the suggested height
  assign prop_gap = surf_q ? sat_gap(DIFF_W'(rd_top) - DIFF_W'(height_q))
                           : sat_gap(DIFF_W'(height_q) - DIFF_W'(rd_bot));
  assign scan_gap = sat_gap(DIFF_W'(rd_top) - DIFF_W'(rd_bot));

  // the first scanned site opens a rescan; the moved site is left out of a
  // proposal rescan, where its proposed gap already seeds the minimum
  assign scan_take = rd_vld_q && !(skip_q && rd_site_q == {row_q, col_q}) &&
                     (first_q || scan_gap < best_q);

  assign eff_rows_m1 = eff_dim(rows_q, ROWS_RST) - DIM_CFG_W'(1);
  assign eff_cols_m1 = eff_dim(cols_q, COLS_RST) - DIM_CFG_W'(1);
  assign last_col    = (scan_col_q == eff_cols_m1[COL_W-1:0]);
  assign last_site   = last_col && (scan_row_q == eff_rows_m1[ROW_W-1:0]);

  // ---------------------------------------------------------------------------
  // energy arithmetic
  // ---------------------------------------------------------------------------
  assign ref_gap    = (cmd_q == CMD_RESCAN) ? target_q : com_min_q;
  // arithmetic shift rounds toward minus infinity
  assign scaled     = prod_q >>> FRAC_BITS;
  assign energy_new = sat_energy(scaled);
  assign energy_sum = PROD_W'(energy_q) + PROD_W'(pend_delta_q);

  assign out_free = !out_valid_q || out_o.ready;

  // ---------------------------------------------------------------------------
  // command sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      cmd_q          <= CMD_LOAD;
      row_q          <= '0;
      col_q          <= '0;
      surf_q         <= 1'b0;
      height_q       <= '0;
      energy_q       <= '0;
      com_min_q      <= GAP_MAX;
      com_row_q      <= '0;
      com_col_q      <= '0;
      pend_min_q     <= GAP_MAX;
      pend_row_q     <= '0;
      pend_col_q     <= '0;
      pend_delta_q   <= '0;
      moved_site_q   <= '0;
      moved_height_q <= '0;
      moved_surf_q   <= 1'b0;
      pend_valid_q   <= 1'b0;
      scan_row_q     <= '0;
      scan_col_q     <= '0;
      rd_vld_q       <= 1'b0;
      rd_site_q      <= '0;
      first_q        <= 1'b0;
      skip_q         <= 1'b0;
      best_q         <= GAP_MAX;
      best_row_q     <= '0;
      best_col_q     <= '0;
      diff_q         <= '0;
      prod_q         <= '0;
      delta_q        <= '0;
    end else begin
      // read pipeline of the scan walk
      rd_vld_q  <= (state_q == ST_SCAN);
      rd_site_q <= rd_addr;
      if (rd_vld_q) begin
        first_q <= 1'b0;
      end
      if (scan_take) begin
        best_q     <= scan_gap;
        best_row_q <= rd_site_q[SITE_W-1:COL_W];
        best_col_q <= rd_site_q[COL_W-1:0];
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            cmd_q    <= in_cmd;
            row_q    <= in_i.row[ROW_W-1:0];
            col_q    <= in_i.col[COL_W-1:0];
            surf_q   <= in_i.surface;
            height_q <= in_i.height;
            delta_q  <= '0;
            case (in_cmd)
              CMD_LOAD: begin
                pend_valid_q <= 1'b0;
                state_q      <= ST_EMIT;
              end
              CMD_RESCAN: begin
                pend_valid_q <= 1'b0;
                scan_row_q   <= '0;
                scan_col_q   <= '0;
                first_q      <= 1'b1;
                skip_q       <= 1'b0;
                state_q      <= ST_SCAN;
              end
              CMD_PROPOSE: begin
                state_q <= ST_PGAP;
              end
              default: begin
                // commit; with nothing pending it only reports
                if (pend_valid_q) begin
                  com_min_q    <= pend_min_q;
                  com_row_q    <= pend_row_q;
                  com_col_q    <= pend_col_q;
                  energy_q     <= sat_energy(energy_sum);
                  pend_valid_q <= 1'b0;
                end
                state_q <= ST_EMIT;
              end
            endcase
          end
        end

        ST_PGAP: begin
          moved_site_q   <= {row_q, col_q};
          moved_height_q <= height_q;
          moved_surf_q   <= surf_q;
          pend_valid_q   <= 1'b1;
          if (row_q == com_row_q && col_q == com_col_q) begin
            // moving the minimum site: rescan around it
            best_q     <= prop_gap;
            best_row_q <= row_q;
            best_col_q <= col_q;
            first_q    <= 1'b0;
            skip_q     <= 1'b1;
            scan_row_q <= '0;
            scan_col_q <= '0;
            state_q    <= ST_SCAN;
          end else if (prop_gap < com_min_q) begin
            best_q     <= prop_gap;
            best_row_q <= row_q;
            best_col_q <= col_q;
            state_q    <= ST_DIFF;
          end else begin
            // minimum unchanged: zero difference gives a zero delta
            best_q     <= com_min_q;
            best_row_q <= com_row_q;
            best_col_q <= com_col_q;
            state_q    <= ST_DIFF;
          end
        end

        ST_SCAN: begin
          if (last_col) begin
            scan_col_q <= '0;
            scan_row_q <= scan_row_q + ROW_W'(1);
          end else begin
            scan_col_q <= scan_col_q + COL_W'(1);
          end
          if (last_site) begin
            state_q <= ST_DRAIN;
          end
        end

        ST_DRAIN: begin
          // last site compares this cycle
          state_q <= ST_DIFF;
        end

        ST_DIFF: begin
          diff_q  <= DIFF_W'(best_q) - DIFF_W'(ref_gap);
          state_q <= ST_MUL;
        end

        ST_MUL: begin
          prod_q  <= PROD_W'(strength_q) * PROD_W'(diff_q);
          state_q <= ST_SAT;
        end

        ST_SAT: begin
          if (cmd_q == CMD_RESCAN) begin
            energy_q  <= energy_new;
            com_min_q <= best_q;
            com_row_q <= best_row_q;
            com_col_q <= best_col_q;
          end else begin
            pend_delta_q <= energy_new;
            pend_min_q   <= best_q;
            pend_row_q   <= best_row_q;
            pend_col_q   <= best_col_q;
            delta_q      <= energy_new;
          end
          state_q <= ST_EMIT;
        end

        ST_EMIT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_EMIT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EMIT && out_free) begin
      out_delta_q  <= delta_q;
      out_energy_q <= energy_q;
      out_min_q    <= com_min_q;
      out_row_q    <= com_row_q;
      out_col_q    <= com_col_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.delta_energy = out_delta_q;
  assign out_o.bias_energy  = out_energy_q;
  assign out_o.min_gap      = out_min_q;
  assign out_o.min_row      = ROW_FIELD_W'(out_row_q);
  assign out_o.min_col      = COL_FIELD_W'(out_col_q);

endmodule

// ----- src/mgbt_grid.sv -----
// top and bottom height grids: one write port and one registered read port
// depends on mgbt_pkg for the grid size and the write request struct
module mgbt_grid import mgbt_pkg::*; (
  input  logic                       clk_i,
  input  grid_wr_t                   wr_i,
  input  logic [SITE_W-1:0]          rd_addr_i,
  output logic signed [HEIGHT_W-1:0] rd_top_o,
  output logic signed [HEIGHT_W-1:0] rd_bot_o
);

  logic [HEIGHT_W-1:0] top_mem [GRID_DEPTH];
  logic [HEIGHT_W-1:0] bot_mem [GRID_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_i.en && !wr_i.surface) begin
      top_mem[wr_i.addr] <= wr_i.data;
    end
    rd_top_o <= top_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_i.surface) begin
      bot_mem[wr_i.addr] <= wr_i.data;
    end
    rd_bot_o <= bot_mem[rd_addr_i];
  end

endmodule

// ----- tb/sv/tb.sv -----
// self-checking testbench of min_gap_bias_tracker_core: directed table, then random phases
// depends on mgbt_pkg, mgbt_in_if, mgbt_out_if and the core; an in-file predictor
// works out every result transfer, checked field by field in arrival order
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mgbt_pkg::*;

  localparam logic signed [HEIGHT_W-1:0] Q_ONE = 32'sh0001_0000;  // 1.0 in Q16.16
  localparam longint E48_TOP = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint E48_BOT = -E48_TOP - 1;
  localparam int unsigned PHASE_ITEMS  = 280;   // commands per random phase, area loads included
  localparam int unsigned NUM_PHASES   = 7;
  localparam int unsigned HOLD_CYCLES  = 600;   // long receiver hold-off
  localparam int unsigned HOLD_AFTER   = 400;   // result transfers seen before the hold-off
  localparam int unsigned SETTLE       = 16;    // quiet cycles before a register write or the end
  localparam int unsigned STALL_LIMIT  = 4000;  // cycles without any transfer before giving up

  // one command as offered on the input channel
  typedef struct {
    cmd_e                       op;
    logic [ROW_FIELD_W-1:0]     row;
    logic [COL_FIELD_W-1:0]     col;
    logic                       surface;
    logic signed [HEIGHT_W-1:0] height;
  } cmd_item_t;

  // what the tracker reports after each command
  typedef struct packed {
    logic signed [ENERGY_W-1:0] delta;
    logic signed [ENERGY_W-1:0] energy;
    logic signed [HEIGHT_W-1:0] gap;
    logic [ROW_FIELD_W-1:0]     mrow;
    logic [COL_FIELD_W-1:0]     mcol;
  } tracker_view_t;

  // one row of the directed table; typed rows carry their expected view
  typedef struct {
    cmd_item_t     item;
    bit            typed;
    tracker_view_t want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  // apb configuration port
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  mgbt_in_if  cmd_if ();
  mgbt_out_if res_if ();

  min_gap_bias_tracker_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (cmd_if),
    .out_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor: grids, committed and pending minimum, energy, register copies
  // ---------------------------------------------------------------------------
  logic signed [HEIGHT_W-1:0] top_h [GRID_DEPTH];
  logic signed [HEIGHT_W-1:0] bot_h [GRID_DEPTH];
  bit                         top_set [GRID_DEPTH];  // entry loaded at least once
  bit                         bot_set [GRID_DEPTH];

  logic signed [ENERGY_W-1:0] energy = '0;
  logic signed [HEIGHT_W-1:0] cmin = GAP_MAX;
  logic [ROW_FIELD_W-1:0]     crow = '0;
  logic [COL_FIELD_W-1:0]     ccol = '0;
  logic signed [HEIGHT_W-1:0] pmin = GAP_MAX;
  logic [ROW_FIELD_W-1:0]     prow = '0;
  logic [COL_FIELD_W-1:0]     pcol = '0;
  logic signed [ENERGY_W-1:0] pdelta = '0;
  int unsigned                mv_site = 0;
  logic signed [HEIGHT_W-1:0] mv_h = '0;
  logic                       mv_surf = 1'b0;
  bit                         pend = 1'b0;

  logic signed [HEIGHT_W-1:0] bias_k   = STRENGTH_RST;
  logic signed [HEIGHT_W-1:0] theta0   = '0;
  logic [DIM_CFG_W-1:0]       rows_cfg = ROWS_RST;
  logic [DIM_CFG_W-1:0]       cols_cfg = COLS_RST;

  tracker_view_t expected_views [$];
  tracker_view_t no_view = '0;
  int unsigned   fail_count   = 0;
  int unsigned   results_seen = 0;
  int unsigned   burst_left   = 0;
  int unsigned   quiet_cycles = 0;

  function automatic logic signed [ENERGY_W-1:0] clamp48(input longint x);
    if (x > E48_TOP) return E48_TOP[ENERGY_W-1:0];
    if (x < E48_BOT) return E48_BOT[ENERGY_W-1:0];
    return x[ENERGY_W-1:0];
  endfunction

  // top - bottom, clamped to 32 bits
  function automatic logic signed [HEIGHT_W-1:0] clamp_gap(input logic signed [HEIGHT_W-1:0] a,
                                                           input logic signed [HEIGHT_W-1:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    if (d > 64'sd2147483647) return GAP_MAX;
    if (d < -64'sd2147483648) return GAP_MIN;
    return d[HEIGHT_W-1:0];
  endfunction

  function automatic logic signed [HEIGHT_W-1:0] site_gap(input int unsigned s);
    return clamp_gap(top_h[s], bot_h[s]);
  endfunction

  // strength * (a - b), floor-scaled by the fraction bits, clamped to 48 bits
  function automatic logic signed [ENERGY_W-1:0] bias_product(input logic signed [HEIGHT_W-1:0] a,
                                                              input logic signed [HEIGHT_W-1:0] b);
    longint d;
    longint p;
    d = longint'(a) - longint'(b);
    p = longint'(bias_k) * d;
    return clamp48(p >>> FRAC_BITS);
  endfunction

  // zero counts as one, oversize counts as the store size
  function automatic int unsigned used_dim(input logic [DIM_CFG_W-1:0] v, input int unsigned lim);
    if (v == '0) return 1;
    if (v > lim) return lim;
    return int'(v);
  endfunction

  // applies one command to the predictor state and returns the view it reports
  function automatic tracker_view_t advance_tracker(input cmd_item_t it);
    int unsigned                site;
    int unsigned                nr;
    int unsigned                nc;
    int unsigned                i;
    int unsigned                j;
    logic signed [HEIGHT_W-1:0] g;
    logic signed [HEIGHT_W-1:0] o;
    logic signed [HEIGHT_W-1:0] best;
    logic [ROW_FIELD_W-1:0]     br;
    logic [COL_FIELD_W-1:0]     bc;
    tracker_view_t              v;
    site = it.row * MAX_COLS + it.col;
    nr = used_dim(rows_cfg, MAX_ROWS);
    nc = used_dim(cols_cfg, MAX_COLS);
    v = '0;
    case (it.op)
      CMD_LOAD: begin
        if (!it.surface) begin
          top_h[site] = it.height;
          top_set[site] = 1'b1;
        end else begin
          bot_h[site] = it.height;
          bot_set[site] = 1'b1;
        end
        pend = 1'b0;
      end
      CMD_RESCAN: begin
        // site (0,0) opens the scan, later sites win only when strictly smaller
        best = site_gap(0);
        br = '0;
        bc = '0;
        for (i = 0; i < nr; i++) begin
          for (j = 0; j < nc; j++) begin
            g = site_gap(i * MAX_COLS + j);
            if (g < best) begin
              best = g;
              br = i[ROW_FIELD_W-1:0];
              bc = j[COL_FIELD_W-1:0];
            end
          end
        end
        cmin = best;
        crow = br;
        ccol = bc;
        energy = bias_product(best, theta0);
        pend = 1'b0;
      end
      CMD_PROPOSE: begin
        g = it.surface ? clamp_gap(top_h[site], it.height) : clamp_gap(it.height, bot_h[site]);
        if (it.row == crow && it.col == ccol) begin
          // moving the minimum site: rescan with its new gap in front
          best = g;
          br = it.row;
          bc = it.col;
          for (i = 0; i < nr; i++) begin
            for (j = 0; j < nc; j++) begin
              if (!(i == it.row && j == it.col)) begin
                o = site_gap(i * MAX_COLS + j);
                if (o < best) begin
                  best = o;
                  br = i[ROW_FIELD_W-1:0];
                  bc = j[COL_FIELD_W-1:0];
                end
              end
            end
          end
          pmin = best;
          prow = br;
          pcol = bc;
          pdelta = bias_product(best, cmin);
        end else if (g < cmin) begin
          pmin = g;
          prow = it.row;
          pcol = it.col;
          pdelta = bias_product(g, cmin);
        end else begin
          pmin = cmin;
          prow = crow;
          pcol = ccol;
          pdelta = '0;
        end
        mv_site = site;
        mv_h = it.height;
        mv_surf = it.surface;
        pend = 1'b1;
        v.delta = pdelta;
      end
      CMD_COMMIT: begin
        if (pend) begin
          if (!mv_surf) top_h[mv_site] = mv_h;
          else bot_h[mv_site] = mv_h;
          cmin = pmin;
          crow = prow;
          ccol = pcol;
          energy = clamp48(longint'(energy) + longint'(pdelta));
          pend = 1'b0;
        end
      end
      default: begin
      end
    endcase
    v.energy = energy;
    v.gap = cmin;
    v.mrow = crow;
    v.mcol = ccol;
    return v;
  endfunction

  // mostly small heights so minima move around, with extremes and full-range values
  function automatic logic signed [HEIGHT_W-1:0] rand_height();
    case ($urandom_range(0, 15))
      0: return GAP_MAX;
      1: return GAP_MIN;
      2, 3, 4: return $urandom;
      default: return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // one apb write; psel stays up so back-to-back writes chain without a gap
  task automatic write_reg(input reg_e idx, input logic [APB_DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    case (idx)
      REG_BIAS_STRENGTH: bias_k = val;
      REG_TARGET_GAP:    theta0 = val;
      REG_ROWS_USED:     rows_cfg = val[DIM_CFG_W-1:0];
      REG_COLS_USED:     cols_cfg = val[DIM_CFG_W-1:0];
      default: begin
      end
    endcase
  endtask

  task automatic apply_settings(input logic [APB_DATA_W-1:0] k, input logic [APB_DATA_W-1:0] t,
                                input logic [DIM_CFG_W-1:0] rows, input logic [DIM_CFG_W-1:0] cols);
    write_reg(REG_BIAS_STRENGTH, k);
    write_reg(REG_TARGET_GAP, t);
    write_reg(REG_ROWS_USED, APB_DATA_W'(rows));
    write_reg(REG_COLS_USED, APB_DATA_W'(cols));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // offers one command, bursts with random gaps in front; records its expected view
  task automatic send_cmd(input cmd_item_t it, input bit typed, input tracker_view_t want);
    tracker_view_t predicted;
    int unsigned   gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 10);
    end
    burst_left--;
    if (gap != 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_if.valid   <= 1'b1;
    cmd_if.cmd     <= it.op;
    cmd_if.row     <= it.row;
    cmd_if.col     <= it.col;
    cmd_if.surface <= it.surface;
    cmd_if.height  <= it.height;
    do @(posedge clk_i); while (cmd_if.ready !== 1'b1);
    predicted = advance_tracker(it);
    expected_views.push_back(typed ? want : predicted);
  endtask

  // waits until every expected view has arrived and the block has gone quiet
  task automatic drain();
    cmd_if.valid <= 1'b0;
    while (expected_views.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic add_row(ref dir_row_t rows [$], input cmd_e op, input int r, input int c,
                         input bit s, input logic signed [HEIGHT_W-1:0] h, input bit typed,
                         input tracker_view_t want);
    dir_row_t d;
    d.item  = '{op, r[ROW_FIELD_W-1:0], c[COL_FIELD_W-1:0], s, h};
    d.typed = typed;
    d.want  = want;
    rows.push_back(d);
  endtask

  // ---------------------------------------------------------------------------
  // result checking, in arrival order
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    tracker_view_t want;
    if (rst_ni === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      results_seen++;
      if (expected_views.size() == 0) begin
        $error("result transfer with nothing expected");
        fail_count++;
      end else begin
        want = expected_views.pop_front();
        if (res_if.delta_energy !== want.delta) begin
          $error("delta_energy: expected %0d, got %0d", want.delta, res_if.delta_energy);
          fail_count++;
        end
        if (res_if.bias_energy !== want.energy) begin
          $error("bias_energy: expected %0d, got %0d", want.energy, res_if.bias_energy);
          fail_count++;
        end
        if (res_if.min_gap !== want.gap) begin
          $error("min_gap: expected %0d, got %0d", want.gap, res_if.min_gap);
          fail_count++;
        end
        if (res_if.min_row !== want.mrow) begin
          $error("min_row: expected %0d, got %0d", want.mrow, res_if.min_row);
          fail_count++;
        end
        if (res_if.min_col !== want.mcol) begin
          $error("min_col: expected %0d, got %0d", want.mcol, res_if.min_col);
          fail_count++;
        end
      end
    end
  end

  // watchdog: gives up after a long run of cycles with no transfer on either channel
  always @(posedge clk_i) begin
    if ((cmd_if.valid === 1'b1 && cmd_if.ready === 1'b1) ||
        (res_if.valid === 1'b1 && res_if.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("min_gap_bias_tracker_core test failed");
      $finish;
    end
  end

  // receiver: segments of its own stall patterns, plus one long hold-off that lets
  // the block fill up while the sender keeps offering
  initial begin : result_backpressure
    int unsigned seg;
    int unsigned mode;
    int unsigned t;
    bit          held;
    held = 1'b0;
    res_if.ready <= 1'b0;
    forever begin
      if (!held && results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        for (t = 0; t < HOLD_CYCLES; t++) begin
          @(posedge clk_i);
          res_if.ready <= 1'b0;
        end
      end
      seg  = $urandom_range(8, 60);
      mode = $urandom_range(0, 3);
      for (t = 0; t < seg; t++) begin
        @(posedge clk_i);
        case (mode)
          0: res_if.ready <= 1'b1;                          // no stalls
          1: res_if.ready <= 1'($urandom_range(0, 1));      // coin flip
          2: res_if.ready <= (t % 3 == 0);                  // one cycle in three
          default: res_if.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    dir_row_t                   dir_q [$];
    tracker_view_t              idle_view;
    tracker_view_t              scan_view;
    cmd_item_t                  it;
    logic [APB_DATA_W-1:0]      k_set;
    logic [APB_DATA_W-1:0]      t_set;
    logic [DIM_CFG_W-1:0]       r_set;
    logic [DIM_CFG_W-1:0]       c_set;
    int unsigned                nr;
    int unsigned                nc;
    int unsigned                ph;
    int unsigned                n;
    int unsigned                i;
    int unsigned                j;
    int unsigned                s;
    int unsigned                pick;
    int unsigned                r;
    int unsigned                c;
    int unsigned                site;

    // every input known from time zero
    rst_ni         <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    cmd_if.valid   <= 1'b0;
    cmd_if.cmd     <= CMD_LOAD;
    cmd_if.row     <= '0;
    cmd_if.col     <= '0;
    cmd_if.surface <= 1'b0;
    cmd_if.height  <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part on a 2x2 area, strength 1.0 and target 0
    apply_settings(Q_ONE, '0, 7'd2, 7'd2);
    idle_view = '{48'sd0, 48'sd0, GAP_MAX, 6'd0, 6'd0};
    scan_view = '{48'sd0, -48'sd2147483648, GAP_MIN, 6'd0, 6'd1};
    // commit with nothing pending, then loads: reset view unchanged
    add_row(dir_q, CMD_COMMIT,  0, 0, 1'b0, '0,      1'b1, idle_view);
    // (0,0) gap clamps high, (0,1) gap clamps low
    add_row(dir_q, CMD_LOAD,    0, 0, 1'b0, GAP_MAX, 1'b1, idle_view);
    add_row(dir_q, CMD_LOAD,    0, 0, 1'b1, GAP_MIN, 1'b1, idle_view);
    add_row(dir_q, CMD_LOAD,    0, 1, 1'b0, GAP_MIN, 1'b1, idle_view);
    add_row(dir_q, CMD_LOAD,    0, 1, 1'b1, GAP_MAX, 1'b1, idle_view);
    add_row(dir_q, CMD_LOAD,    1, 0, 1'b0, 5 * Q_ONE, 1'b1, idle_view);
    add_row(dir_q, CMD_LOAD,    1, 0, 1'b1, 2 * Q_ONE, 1'b1, idle_view);
    add_row(dir_q, CMD_LOAD,    1, 1, 1'b0, '0,      1'b1, idle_view);
    add_row(dir_q, CMD_LOAD,    1, 1, 1'b1, Q_ONE,   1'b1, idle_view);
    // rescan: most negative gap at (0,1), energy = -2^31
    add_row(dir_q, CMD_RESCAN,  0, 0, 1'b0, '0,      1'b1, scan_view);
    // proposals at the minimum site rescan; a second proposal replaces the first
    add_row(dir_q, CMD_PROPOSE, 0, 1, 1'b1, '0,      1'b0, no_view);
    add_row(dir_q, CMD_PROPOSE, 0, 1, 1'b0, '0,      1'b0, no_view);
    add_row(dir_q, CMD_COMMIT,  0, 0, 1'b0, '0,      1'b0, no_view);
    // elsewhere: a tie loses, a strictly smaller gap wins
    add_row(dir_q, CMD_PROPOSE, 1, 1, 1'b1, GAP_MAX, 1'b0, no_view);
    add_row(dir_q, CMD_PROPOSE, 1, 0, 1'b0, GAP_MIN, 1'b0, no_view);
    // a load throws the proposal away, the commit after it does nothing
    add_row(dir_q, CMD_LOAD,    1, 1, 1'b0, '0,      1'b0, no_view);
    add_row(dir_q, CMD_COMMIT,  0, 0, 1'b0, '0,      1'b0, no_view);
    add_row(dir_q, CMD_PROPOSE, 1, 0, 1'b0, GAP_MIN, 1'b0, no_view);
    add_row(dir_q, CMD_COMMIT,  0, 0, 1'b0, '0,      1'b0, no_view);
    add_row(dir_q, CMD_PROPOSE, 1, 0, 1'b0, 7 * Q_ONE, 1'b0, no_view);
    add_row(dir_q, CMD_COMMIT,  0, 0, 1'b0, '0,      1'b0, no_view);
    // far corner, outside the used area: loaded and proposed all the same
    add_row(dir_q, CMD_LOAD,    63, 63, 1'b0, 32'sh1234_5678, 1'b0, no_view);
    add_row(dir_q, CMD_LOAD,    63, 63, 1'b1, -Q_ONE, 1'b0, no_view);
    add_row(dir_q, CMD_PROPOSE, 63, 63, 1'b0, -5 * Q_ONE, 1'b0, no_view);
    add_row(dir_q, CMD_RESCAN,  0, 0, 1'b0, '0,      1'b0, no_view);
    foreach (dir_q[d]) send_cmd(dir_q[d].item, dir_q[d].typed, dir_q[d].want);
    drain();

    // random phases, each under its own register setting
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          k_set = Q_ONE;   t_set = '0;      r_set = 7'd8;   c_set = 7'd8;
        end
        1: begin
          // strongest spring, lowest target: energies saturate; zero rows acts as one
          k_set = GAP_MAX; t_set = GAP_MIN; r_set = 7'd0;   c_set = 7'd64;
        end
        2: begin
          // most negative spring, highest target; oversize rows clamp to the store
          k_set = GAP_MIN; t_set = GAP_MAX; r_set = 7'd127; c_set = 7'd1;
        end
        3: begin
          k_set = $urandom; t_set = $urandom; r_set = 7'd5; c_set = 7'd7;
        end
        4: begin
          k_set = '0;
          t_set = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
          r_set = 7'd3;    c_set = 7'd3;
        end
        5: begin
          // single used site: proposals mostly fall on the minimum site
          k_set = $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
          t_set = $urandom; r_set = 7'd1; c_set = 7'd1;
        end
        default: begin
          k_set = $urandom; t_set = '0; r_set = 7'd4; c_set = 7'd4;
        end
      endcase
      apply_settings(k_set, t_set, r_set, c_set);
      nr = used_dim(rows_cfg, MAX_ROWS);
      nc = used_dim(cols_cfg, MAX_COLS);
      n  = 0;

      // fill the used area on both sheets, then establish the minimum
      for (i = 0; i < nr; i++) begin
        for (j = 0; j < nc; j++) begin
          for (s = 0; s < 2; s++) begin
            it = '{CMD_LOAD, i[ROW_FIELD_W-1:0], j[COL_FIELD_W-1:0], s[0], rand_height()};
            send_cmd(it, 1'b0, no_view);
            n++;
          end
        end
      end
      it = '{CMD_RESCAN, ROW_FIELD_W'($urandom), COL_FIELD_W'($urandom), 1'($urandom),
             $urandom};
      send_cmd(it, 1'b0, no_view);
      n++;

      while (n < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
          // loads mostly inside the used area, some anywhere in the store
          if ($urandom_range(0, 9) < 7) begin
            r = $urandom_range(0, nr - 1);
            c = $urandom_range(0, nc - 1);
          end else begin
            r = $urandom_range(0, MAX_ROWS - 1);
            c = $urandom_range(0, MAX_COLS - 1);
          end
          it = '{CMD_LOAD, r[ROW_FIELD_W-1:0], c[COL_FIELD_W-1:0], 1'($urandom),
                 rand_height()};
          send_cmd(it, 1'b0, no_view);
          n++;
        end else if (pick < 35) begin
          // rescan with junk in the unused fields
          it = '{CMD_RESCAN, ROW_FIELD_W'($urandom), COL_FIELD_W'($urandom), 1'($urandom),
                 $urandom};
          send_cmd(it, 1'b0, no_view);
          n++;
        end else if (pick < 45) begin
          // lone commit: applies a leftover proposal or does nothing
          it = '{CMD_COMMIT, ROW_FIELD_W'($urandom), COL_FIELD_W'($urandom), 1'($urandom),
                 $urandom};
          send_cmd(it, 1'b0, no_view);
          n++;
        end else begin
          // proposal, usually followed by its commit
          pick = $urandom_range(0, 99);
          if (pick < 40) begin
            r = crow;
            c = ccol;
          end else begin
            r = $urandom_range(0, nr - 1);
            c = $urandom_range(0, nc - 1);
            if (pick >= 85) begin
              // any site in the store whose both sheets are loaded
              site = $urandom_range(0, GRID_DEPTH - 1);
              if (top_set[site] && bot_set[site]) begin
                r = site / MAX_COLS;
                c = site % MAX_COLS;
              end
            end
          end
          it = '{CMD_PROPOSE, r[ROW_FIELD_W-1:0], c[COL_FIELD_W-1:0], 1'($urandom),
                 rand_height()};
          send_cmd(it, 1'b0, no_view);
          n++;
          if ($urandom_range(0, 9) < 7) begin
            it = '{CMD_COMMIT, ROW_FIELD_W'($urandom), COL_FIELD_W'($urandom), 1'($urandom),
                   $urandom};
            send_cmd(it, 1'b0, no_view);
            n++;
          end
        end
      end
      drain();
    end

    if (fail_count == 0 && expected_views.size() == 0) begin
      $display("min_gap_bias_tracker_core test passed");
    end else begin
      $display("min_gap_bias_tracker_core test failed");
    end
    $finish;
  end

endmodule
